// ===== hdl/bsu_pkg.sv =====
// Shared types and constants for the bounding sphere union fold block.
// Has no dependencies; every other file of the block depends on it.
package bsu_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int AXES           = 3;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_ROOT = 9'b000000100,
    S_CMP  = 9'b000001000,
    S_MULO = 9'b000010000,
    S_DLD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

endpackage

// ===== hdl/bsu_in_if.sv =====
// Input channel of the bounding sphere union fold: one sphere request per handshake.
// Depends on bsu_pkg for the default coordinate width.
interface bsu_in_if #(parameter int COORD_BITS = bsu_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS-2:0] radius;
  logic                         no_geometry;
  logic                         last_sphere;

  modport source (output valid, center_x, center_y, center_z, radius, no_geometry,
                  last_sphere, input ready);
  modport sink (input valid, center_x, center_y, center_z, radius, no_geometry,
                last_sphere, output ready);
endinterface

// ===== hdl/bsu_out_if.sv =====
// Result channel of the bounding sphere union fold: one merged sphere per handshake.
// Depends on bsu_pkg for the default coordinate width.
interface bsu_out_if #(parameter int COORD_BITS = bsu_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] merged_x;
  logic signed [COORD_BITS-1:0] merged_y;
  logic signed [COORD_BITS-1:0] merged_z;
  logic signed [COORD_BITS-1:0] merged_radius;

  modport source (output valid, merged_x, merged_y, merged_z, merged_radius, input ready);
  modport sink (input valid, merged_x, merged_y, merged_z, merged_radius, output ready);
endinterface

// ===== hdl/bsu_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Used for the squared distances and the center offsets; depends on bsu_pkg for the default width.
module bsu_mul #(
  parameter int W = bsu_pkg::COORD_BITS_DEF + 1
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
  end
endmodule

// ===== hdl/bsu_csub.sv =====
// Shared compare and subtract unit, one step of the square root and the divider.
// Depends on bsu_pkg for the default width.
module bsu_csub #(
  parameter int W = bsu_pkg::COORD_BITS_DEF + 5
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);
  assign ge   = (a >= b);
  assign diff = a - b;
endmodule

// ===== hdl/bounding_sphere_union_fold_top.sv =====
// Bounding sphere union fold: sequencer and datapath around the shared units.
// Depends on bsu_pkg, bsu_in_if, bsu_out_if, bsu_mul and bsu_csub.
//
// Usage: spheres arrive as requests on in_chan (valid/ready). Each sphere
// without no_geometry is folded into an accumulated sphere. A request with
// last_sphere set causes one request on out_chan with the merged sphere, after
// which the accumulator is cleared; an empty group yields a zero center and
// radius -1.0. Sequencing: in_chan.ready is high only while the sequencer is
// idle. The first sphere of a group is stored directly by the idle state. A
// merge computes the squared distance, takes the bit-serial square root, makes
// a compare, and then runs the offset multiply and the restoring divide for
// each axis in turn. A merge in which one sphere contains the other ends after
// the compare. The square root and the divide share the compare-subtract unit.
// The result sits in an output register; a stalled receiver blocks only the
// next emission. Reset clears the accumulator and the output valid.
module bounding_sphere_union_fold_top #(
  parameter int COORD_BITS = bsu_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bsu_pkg::FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  bsu_in_if.sink   in_chan,
  bsu_out_if.source out_chan
);
  import bsu_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int MW   = CW + 1;
  localparam int PW   = 2 * MW;
  localparam int RW   = CW + 5;
  localparam int CNTW = $clog2(CW + 1);

  state_t state_r, state_nxt;

  logic signed [CW-1:0] acc_r [AXES];
  logic signed [CW-1:0] acc_nxt [AXES];
  logic [CW-2:0]        acc_rad_r, acc_rad_nxt;
  logic                 acc_valid_r, acc_valid_nxt;
  logic signed [CW-1:0] b_r [AXES];
  logic signed [CW-1:0] b_nxt [AXES];
  logic [CW-2:0]        b_rad_r, b_rad_nxt;
  logic                 last_r, last_nxt;
  logic [MW-1:0]        mag_r [AXES];
  logic [MW-1:0]        mag_nxt [AXES];
  logic                 neg_r [AXES];
  logic                 neg_nxt [AXES];
  logic [PW-1:0]        sq_r, sq_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [MW-1:0]        root_r, root_nxt;
  logic [CW-1:0]        num_r, num_nxt;
  logic [CW-1:0]        quot_r, quot_nxt;
  logic [MW-1:0]        step_r, step_nxt;
  logic [CW-2:0]        rad_new_r, rad_new_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [1:0]           axis_r, axis_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r, out_rad_r;
  logic signed [CW-1:0] out_x_nxt, out_y_nxt, out_z_nxt, out_rad_nxt;

  logic [MW-1:0]  mul_a, mul_b;
  logic [PW-1:0]  prod;
  logic [RW-1:0]  cs_a, cs_b, cs_diff;
  logic           cs_ge;
  logic [1:0]     sel;
  logic           accept;
  logic signed [MW-1:0] dx [AXES];
  logic [CW+1:0]  dist_e, ra_e, rb_e, tot;
  logic [MW-1:0]  big;

  bsu_mul #(.W(MW)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));
  bsu_csub #(.W(RW)) u_csub (.a(cs_a), .b(cs_b), .ge(cs_ge), .diff(cs_diff));

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.merged_x      = out_x_r;
  assign out_chan.merged_y      = out_y_r;
  assign out_chan.merged_z      = out_z_r;
  assign out_chan.merged_radius = out_rad_r;

  always_comb begin
    sel = axis_r;
    if (state_r == S_SQ) begin
      sel = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
    end
    mul_a = mag_r[sel];
    mul_b = (state_r == S_SQ) ? mag_r[sel] : step_r;
  end

  always_comb begin
    if (state_r == S_ROOT) begin
      cs_a = {rem_r[RW-3:0], sq_r[PW-1:PW-2]};
      cs_b = {{(RW-MW-2){1'b0}}, root_r, 2'b01};
    end else begin
      cs_a = {rem_r[RW-2:0], num_r[CW-1]};
      cs_b = {{(RW-MW){1'b0}}, root_r};
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      dx[i] = MW'({in_chan.center_x[CW-1], in_chan.center_x}) -
              MW'({acc_r[i][CW-1], acc_r[i]});
    end
    dx[1] = MW'({in_chan.center_y[CW-1], in_chan.center_y}) -
            MW'({acc_r[1][CW-1], acc_r[1]});
    dx[2] = MW'({in_chan.center_z[CW-1], in_chan.center_z}) -
            MW'({acc_r[2][CW-1], acc_r[2]});
  end

  assign dist_e = {1'b0, root_r};
  assign ra_e   = {3'b000, acc_rad_r};
  assign rb_e   = {3'b000, b_rad_r};
  assign tot    = dist_e + ra_e + rb_e;
  assign big    = tot[CW+1:1];

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    acc_rad_nxt   = acc_rad_r;
    acc_valid_nxt = acc_valid_r;
    b_nxt         = b_r;
    b_rad_nxt     = b_rad_r;
    last_nxt      = last_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    num_nxt       = num_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    rad_new_nxt   = rad_new_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_rad_nxt   = out_rad_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          b_nxt[0]  = in_chan.center_x;
          b_nxt[1]  = in_chan.center_y;
          b_nxt[2]  = in_chan.center_z;
          b_rad_nxt = in_chan.radius;
          last_nxt  = in_chan.last_sphere;
          for (int i = 0; i < AXES; i++) begin
            neg_nxt[i] = dx[i][CW];
            mag_nxt[i] = dx[i][CW] ? MW'(-dx[i]) : MW'(dx[i]);
          end
          if (!in_chan.no_geometry && acc_valid_r) begin
            cnt_nxt   = '0;
            state_nxt = S_SQ;
          end else begin
            if (!in_chan.no_geometry) begin
              acc_nxt[0]    = in_chan.center_x;
              acc_nxt[1]    = in_chan.center_y;
              acc_nxt[2]    = in_chan.center_z;
              acc_rad_nxt   = in_chan.radius;
              acc_valid_nxt = 1'b1;
            end
            state_nxt = in_chan.last_sphere ? S_EMIT : S_IDLE;
          end
        end
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd1) begin
          sq_nxt = prod;
        end else if (cnt_r[1:0] != 2'd0) begin
          sq_nxt = sq_r + prod;
        end
        if (cnt_r[1:0] == 2'd3) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNTW'(CW);
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        sq_nxt   = {sq_r[PW-3:0], 2'b00};
        root_nxt = {root_r[MW-2:0], cs_ge};
        rem_nxt  = cs_ge ? cs_diff : cs_a;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (ra_e >= dist_e + rb_e) begin
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end else if (rb_e >= dist_e + ra_e) begin
          acc_nxt     = b_r;
          acc_rad_nxt = b_rad_r;
          state_nxt   = last_r ? S_EMIT : S_IDLE;
        end else begin
          step_nxt    = big - {2'b00, acc_rad_r};
          rad_new_nxt = (big[MW-1:MW-2] != 2'b00) ? {(CW-1){1'b1}} : big[CW-2:0];
          axis_nxt    = '0;
          state_nxt   = S_MULO;
        end
      end
      S_MULO: begin
        state_nxt = S_DLD;
      end
      S_DLD: begin
        rem_nxt   = {{(RW-(PW-CW)){1'b0}}, prod[PW-1:CW]};
        num_nxt   = prod[CW-1:0];
        quot_nxt  = '0;
        cnt_nxt   = CNTW'(CW - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        num_nxt  = {num_r[CW-2:0], 1'b0};
        quot_nxt = {quot_r[CW-2:0], cs_ge};
        rem_nxt  = cs_ge ? cs_diff : cs_a;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        acc_nxt[axis_r] = neg_r[axis_r] ? acc_r[axis_r] - quot_r : acc_r[axis_r] + quot_r;
        if (axis_r == 2'd2) begin
          acc_rad_nxt = rad_new_r;
          state_nxt   = last_r ? S_EMIT : S_IDLE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MULO;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          if (acc_valid_r) begin
            out_x_nxt   = acc_r[0];
            out_y_nxt   = acc_r[1];
            out_z_nxt   = acc_r[2];
            out_rad_nxt = {1'b0, acc_rad_r};
          end else begin
            out_x_nxt   = '0;
            out_y_nxt   = '0;
            out_z_nxt   = '0;
            out_rad_nxt = -(CW'(1) << FRAC_BITS);
          end
          for (int i = 0; i < AXES; i++) begin
            acc_nxt[i] = '0;
          end
          acc_rad_nxt   = '0;
          acc_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_valid_r <= 1'b0;
      acc_rad_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      acc_valid_r <= acc_valid_nxt;
      acc_rad_r   <= acc_rad_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r       <= b_nxt;
    b_rad_r   <= b_rad_nxt;
    last_r    <= last_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    sq_r      <= sq_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    num_r     <= num_nxt;
    quot_r    <= quot_nxt;
    step_r    <= step_nxt;
    rad_new_r <= rad_new_nxt;
    cnt_r     <= cnt_nxt;
    axis_r    <= axis_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_z_r   <= out_z_nxt;
    out_rad_r <= out_rad_nxt;
  end

  // An empty accumulator always holds a zero radius.
  a_empty_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !acc_valid_r |-> (acc_rad_r == '0))
    else $error("accumulator radius not cleared while empty");

  // The square root remainder never exceeds twice the partial root.
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (rem_r <= {{(RW-MW-1){1'b0}}, root_r, 1'b0}))
    else $error("square root remainder out of range");

  // The divider remainder stays below the distance.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < {{(RW-MW){1'b0}}, root_r}))
    else $error("divider remainder not below divisor");

  // A result request is raised only by the emit state.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

endmodule
